// File: hdl/atlf_pkg.sv
// ----------------------------------------------------------------------------
// atlf_pkg
// Shared constants, types and helpers of the AT response line framer.
// ----------------------------------------------------------------------------
package atlf_pkg;

    // Line buffer sizing. At most LINE_MAX-2 content bytes are kept.
    localparam int LINE_MAX    = 64;
    localparam int STORE_CAP   = LINE_MAX - 2;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int HEAD_LEN    = 5;

    // Characters of interest.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    // First bytes of a line; entry 0 is the first received byte.
    typedef logic [HEAD_LEN-1:0][7:0] t_head;

    // Unsolicited SMS headers that pull in the following line.
    localparam t_head SMS_CMT = {8'h3A, 8'h54, 8'h4D, 8'h43, 8'h2B};
    localparam t_head SMS_CDS = {8'h3A, 8'h53, 8'h44, 8'h43, 8'h2B};
    localparam t_head SMS_CBM = {8'h3A, 8'h4D, 8'h42, 8'h43, 8'h2B};

    // Line store access from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    // One result transaction.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_valid;
        logic       line_last;
        logic       line_overflow;
    } t_item;

    function automatic logic is_sms_head(input t_head head);
        return (head == SMS_CMT) || (head == SMS_CDS) || (head == SMS_CBM);
    endfunction

endpackage

// File: hdl/atlf_store.sv
// ----------------------------------------------------------------------------
// atlf_store
// Line content memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module atlf_store (
    input  logic                  i_clk,
    input  atlf_pkg::t_store_req  i_req,
    output logic [7:0]            o_rd_data
);

    logic [7:0] r_mem [atlf_pkg::STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/atlf_seq.sv
// ----------------------------------------------------------------------------
// atlf_seq
// Framing state machine and emission sequencer of the line framer.
// ----------------------------------------------------------------------------
module atlf_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_in_byte,
    output logic                  o_in_ready,
    output atlf_pkg::t_store_req  o_store,
    input  logic [7:0]            i_rd_data,
    input  logic                  i_out_free,
    output logic                  o_emit,
    output atlf_pkg::t_item       o_item
);

    typedef enum logic [2:0] {
        S_IDLE, S_APPLF, S_FETCH, S_CHECK, S_EMPTY, S_GT, S_SP
    } t_state;

    typedef enum logic [1:0] {
        PH_WAIT_CR, PH_WAIT_LF, PH_COLLECT, PH_WAIT_END
    } t_phase;

    localparam int LW = atlf_pkg::LEN_W;

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic                  r_sms, n_sms;
    logic [LW-1:0]         r_len, n_len;
    logic                  r_dropped, n_dropped;
    atlf_pkg::t_head       r_head, n_head;
    logic [LW-1:0]         r_idx, n_idx;
    logic [7:0]            r_cur, n_cur;
    logic                  r_have, n_have;

    logic                  app_en;
    logic [7:0]            app_byte;
    logic                  can_app;
    logic                  lone_gt;
    logic                  term;

    assign can_app = (r_len < LW'(atlf_pkg::STORE_CAP)) &&
                     (r_len < LW'(atlf_pkg::STORE_DEPTH));
    assign lone_gt = (r_len == LW'(1)) && (r_head[0] == atlf_pkg::CH_GT);
    // The shared byte compare: end of stored data or a zero byte ends a line.
    assign term    = (r_idx >= r_len) || (i_rd_data == atlf_pkg::CH_NUL);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_sms     = r_sms;
        n_len     = r_len;
        n_dropped = r_dropped;
        n_head    = r_head;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_have    = r_have;
        app_en    = 1'b0;
        app_byte  = i_in_byte;
        o_in_ready = 1'b0;
        o_emit    = 1'b0;
        o_item    = '0;
        o_item.line_overflow = r_dropped;
        o_store.raddr = r_idx[atlf_pkg::ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (r_phase)
                        PH_WAIT_CR: begin
                            if (i_in_byte == atlf_pkg::CH_CR) begin
                                n_phase = PH_WAIT_LF;
                                n_sms   = 1'b0;
                            end
                        end
                        PH_WAIT_LF: begin
                            if (i_in_byte == atlf_pkg::CH_LF) begin
                                n_phase = PH_COLLECT;
                            end
                        end
                        PH_COLLECT: begin
                            if (i_in_byte == atlf_pkg::CH_CR) begin
                                n_phase = PH_WAIT_END;
                            end else begin
                                app_en = 1'b1;
                                if (r_len == '0 && i_in_byte == atlf_pkg::CH_GT) begin
                                    n_phase = PH_WAIT_END;
                                end
                            end
                        end
                        default: begin
                            if (i_in_byte == atlf_pkg::CH_LF) begin
                                if (lone_gt) begin
                                    n_state = S_EMPTY;
                                end else if (!r_sms &&
                                             r_len >= LW'(atlf_pkg::HEAD_LEN) &&
                                             atlf_pkg::is_sms_head(r_head)) begin
                                    // Keep CR LF between the two lines of the pair.
                                    app_en   = 1'b1;
                                    app_byte = atlf_pkg::CH_CR;
                                    n_sms    = 1'b1;
                                    n_phase  = PH_COLLECT;
                                    n_state  = S_APPLF;
                                end else begin
                                    n_idx   = '0;
                                    n_have  = 1'b0;
                                    n_state = S_FETCH;
                                end
                            end else if (i_in_byte == atlf_pkg::CH_SP && lone_gt) begin
                                n_state = S_GT;
                            end
                        end
                    endcase
                end
            end
            S_APPLF: begin
                app_en   = 1'b1;
                app_byte = atlf_pkg::CH_LF;
                n_state  = S_IDLE;
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // One byte is held back so that the last one can be marked.
                if (term) begin
                    if (i_out_free) begin
                        o_emit = 1'b1;
                        o_item.line_byte  = r_have ? r_cur : 8'h00;
                        o_item.byte_valid = r_have;
                        o_item.line_last  = 1'b1;
                        n_len     = '0;
                        n_dropped = 1'b0;
                        n_phase   = PH_WAIT_CR;
                        n_state   = S_IDLE;
                    end
                end else if (r_have) begin
                    if (i_out_free) begin
                        o_emit = 1'b1;
                        o_item.line_byte  = r_cur;
                        o_item.byte_valid = 1'b1;
                        n_cur   = i_rd_data;
                        n_idx   = r_idx + LW'(1);
                        n_state = S_FETCH;
                    end
                end else begin
                    n_cur   = i_rd_data;
                    n_have  = 1'b1;
                    n_idx   = r_idx + LW'(1);
                    n_state = S_FETCH;
                end
            end
            S_EMPTY: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    o_item.line_last = 1'b1;
                    n_len     = '0;
                    n_dropped = 1'b0;
                    n_phase   = PH_WAIT_CR;
                    n_state   = S_IDLE;
                end
            end
            S_GT: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    o_item.line_byte  = atlf_pkg::CH_GT;
                    o_item.byte_valid = 1'b1;
                    n_state = S_SP;
                end
            end
            S_SP: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    o_item.line_byte  = atlf_pkg::CH_SP;
                    o_item.byte_valid = 1'b1;
                    o_item.line_last  = 1'b1;
                    n_len     = '0;
                    n_dropped = 1'b0;
                    n_phase   = PH_WAIT_CR;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append into the line store, or mark the line when it is full.
        o_store.we    = 1'b0;
        o_store.waddr = r_len[atlf_pkg::ADDR_W-1:0];
        o_store.wdata = app_byte;
        if (app_en) begin
            if (can_app) begin
                o_store.we = 1'b1;
                n_len      = r_len + LW'(1);
                if (r_len < LW'(atlf_pkg::HEAD_LEN)) begin
                    n_head[r_len[2:0]] = app_byte;
                end
            end else begin
                n_dropped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_WAIT_CR;
            r_sms     <= 1'b0;
            r_len     <= '0;
            r_dropped <= 1'b0;
            r_have    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_sms     <= n_sms;
            r_len     <= n_len;
            r_dropped <= n_dropped;
            r_have    <= n_have;
            r_idx     <= n_idx;
        end
        r_head <= n_head;
        r_cur  <= n_cur;
    end

endmodule

// File: hdl/at_response_line_framer_top.sv
// ----------------------------------------------------------------------------
// at_response_line_framer_top
// Frames AT command responses from a modem receive byte stream.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one received modem byte per transaction in tdata.
// The master channel gives the framed lines, one byte per transaction: tdata
// holds the byte, tlast marks the final byte of a line, tuser[0] says tdata
// holds data (low for the single transaction of an empty line) and tuser[1]
// says bytes of the line were dropped because the line buffer was full.
// A byte that completes no line leaves the input ready for the next byte.
// The LF that ends the first line of a kept SMS pair holds off the next
// byte while CR and LF are both written to the store.
// The LF that ends a line starts the emission sequencer, which walks the line
// store through its single read port and one byte compare, passing through
// a fetch and a check state for each output byte. A prompt ("> ") is given
// as '>' and ' ' without reading the store; a lone '>' line is given as
// the single transaction of an empty line. No new byte is taken while a
// line is emitted.
// A stalled receiver holds the current result in the output register and
// the sequencer waits; the final result may still wait while the next
// input byte is already taken. Reset is synchronous and clears the framing
// state and the output valid; the line store needs no clearing.
// ----------------------------------------------------------------------------
module at_response_line_framer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] line_byte
    output logic       o_m_axis_tlast,   // line_last
    output logic [1:0] o_m_axis_tuser    // [0] byte_valid, [1] line_overflow
);

    atlf_pkg::t_store_req store_req;
    logic [7:0]           rd_data;
    logic                 out_free;
    logic                 emit;
    atlf_pkg::t_item      item;

    logic                 r_out_valid;
    atlf_pkg::t_item      r_out_item;

    atlf_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    atlf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_byte  (i_s_axis_tdata),
        .o_in_ready (o_s_axis_tready),
        .o_store    (store_req),
        .i_rd_data  (rd_data),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_item     (item)
    );

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
        if (out_free && emit) begin
            r_out_item <= item;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_item.line_byte;
    assign o_m_axis_tlast    = r_out_item.line_last;
    assign o_m_axis_tuser[0] = r_out_item.byte_valid;
    assign o_m_axis_tuser[1] = r_out_item.line_overflow;

endmodule

// File: hdl/atlf_checker.sv
// ----------------------------------------------------------------------------
// atlf_checker
// Port-level checks of the line framer, bound to the top level.
// ----------------------------------------------------------------------------
module atlf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic [1:0] o_m_axis_tuser
);

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) &&
         $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    // An empty line marker is a single last transaction with zero data.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
        (o_m_axis_tlast && o_m_axis_tdata == 8'h00))
        else $error("empty line marker malformed");

    // Reset empties the output register and leaves the input side ready.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind at_response_line_framer_top atlf_checker u_atlf_checker (.*);
